/* rtl/core/crcfr_pkg.sv */
// crcfr_pkg: shared types and constants of the CRC-8 frame receiver.
// Used by the CRC unit and the top-level sequencer; depends on nothing.
package crcfr_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [7:0]  START_BYTE_RST   = 8'd170;
  localparam logic [7:0]  EXP_CMD_RST      = 8'd0;
  localparam logic [5:0]  PAYLOAD_LIM_RST  = 6'd63;
  localparam logic [15:0] TIMEOUT_RST      = 16'd200;

  localparam logic [1:0] REG_START_BYTE  = 2'd0;
  localparam logic [1:0] REG_EXP_CMD     = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_LIM = 2'd2;
  localparam logic [1:0] REG_TIMEOUT     = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_ZERO_LEN  = 3'd1;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd2;
  localparam logic [2:0] STAT_CRC_BAD   = 3'd3;
  localparam logic [2:0] STAT_CMD_BAD   = 3'd4;
  localparam logic [2:0] STAT_OVER_LIM  = 3'd5;
  localparam logic [2:0] STAT_TIMEOUT   = 3'd6;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_CRC  = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CRC  = 4'b0010,
    S_RD   = 4'b0100,
    S_EMIT = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] seed;
  } crc_req_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] crc;
  } crc_stat_t;

endpackage

/* rtl/core/crcfr_if.sv */
// crcfr_if: valid/ready channels for received words and result words.
// Depends on nothing.
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last;
  logic [2:0] status;
  logic [5:0] payload_length;
  modport source (output valid, output data_byte, output has_data, output last,
                  output status, output payload_length, input ready);
  modport sink   (input valid, input data_byte, input has_data, input last,
                  input status, input payload_length, output ready);
endinterface

/* rtl/core/crc8_frame_receiver_unit.sv */
// crc8_frame_receiver_unit: start/length/body/CRC-8 deframer, top level.
// Ticks and hunting bytes are taken while idle; length and body bytes each start
// the bit-serial CRC unit (8 shifts) and hold off further words until it is done.
// Payload words pass a registered body memory read each. Errors: a single word.
// Synchronous active-high reset: hunting, counters zero, registers at defaults;
// body memory is not cleared. Depends on crcfr_pkg, crcfr_if, crcfr_crc_unit,
// crcfr_body_buf.
module crc8_frame_receiver_unit #(
  parameter int BODY_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  crcfr_in_if.sink    in_ch,
  crcfr_out_if.source out_ch
);
  import crcfr_pkg::*;

  localparam int AW = (BODY_BYTES > 1) ? $clog2(BODY_BYTES) : 1;
  localparam int CW = $clog2(BODY_BYTES + 1);
  localparam int MW = (CW > 8) ? CW : 8;

  logic [7:0]  start_byte;
  logic [7:0]  expected_command;
  logic [5:0]  payload_limit;
  logic [15:0] timeout_ticks;

  seq_state_t  state;
  phase_t      phase;
  logic [7:0]  frame_length;
  logic [CW-1:0] byte_count;
  logic [15:0] tick_count;
  logic [7:0]  cmd;
  logic [5:0]  pl_q;
  logic [AW-1:0] rd_addr;

  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_has;
  logic        out_last;
  logic [2:0]  out_status;
  logic [5:0]  out_plen;

  crc_req_t    crc_req;
  crc_stat_t   crc_stat;
  logic [7:0]  rd_data;

  logic          accept;
  logic          out_free;
  logic          emit_word;
  logic          st_emit;
  logic [2:0]    st_code;
  logic          good;
  logic          mem_we;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    pl;
  logic          rd_last;

  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign accept = in_ch.valid && in_ch.ready;
  assign cnt_inc = byte_count + 1'b1;
  assign pl = frame_length - 8'd1;
  assign rd_last = (8'(rd_addr) == {2'b00, pl_q});
  assign emit_word = ((state == S_IDLE) && st_emit) || ((state == S_EMIT) && out_free);

  always_comb begin
    st_emit = 1'b0;
    st_code = STAT_OK;
    good    = 1'b0;
    mem_we  = 1'b0;
    crc_req = '0;
    if (state == S_IDLE && accept) begin
      if (in_ch.kind) begin
        if (phase != PH_HUNT && tick_count >= timeout_ticks) begin
          st_emit = 1'b1;
          st_code = STAT_TIMEOUT;
        end
      end else begin
        unique case (phase)
          PH_HUNT: begin
          end
          PH_LEN: begin
            if (in_ch.rx_byte == 8'd0) begin
              st_emit = 1'b1;
              st_code = STAT_ZERO_LEN;
            end else if ({1'b0, in_ch.rx_byte} > 9'(BODY_BYTES)) begin
              st_emit = 1'b1;
              st_code = STAT_TOO_LONG;
            end else begin
              crc_req.start = 1'b1;
              crc_req.seed  = in_ch.rx_byte;
            end
          end
          PH_BODY: begin
            mem_we        = 1'b1;
            crc_req.start = 1'b1;
            crc_req.seed  = crc_stat.crc ^ in_ch.rx_byte;
          end
          PH_CRC: begin
            if (in_ch.rx_byte != crc_stat.crc) begin
              st_emit = 1'b1;
              st_code = STAT_CRC_BAD;
            end else if (cmd != expected_command) begin
              st_emit = 1'b1;
              st_code = STAT_CMD_BAD;
            end else if (pl > {2'b00, payload_limit}) begin
              st_emit = 1'b1;
              st_code = STAT_OVER_LIM;
            end else if (pl == 8'd0) begin
              // good frame, empty payload: one closing word
              st_emit = 1'b1;
              st_code = STAT_OK;
            end else begin
              good = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte       <= START_BYTE_RST;
      expected_command <= EXP_CMD_RST;
      payload_limit    <= PAYLOAD_LIM_RST;
      timeout_ticks    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:  start_byte       <= cfg_data[7:0];
        REG_EXP_CMD:     expected_command <= cfg_data[7:0];
        REG_PAYLOAD_LIM: payload_limit    <= cfg_data[5:0];
        REG_TIMEOUT:     timeout_ticks    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_HUNT;
      frame_length <= 8'd0;
      byte_count   <= '0;
      tick_count   <= 16'd0;
      out_valid    <= 1'b0;
    end else begin
      if (emit_word) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (st_emit) begin
            out_data   <= 8'd0;
            out_has    <= 1'b0;
            out_last   <= 1'b1;
            out_status <= st_code;
            out_plen   <= 6'd0;
            phase      <= PH_HUNT;
          end else if (accept) begin
            if (in_ch.kind) begin
              if (phase != PH_HUNT) begin
                tick_count <= tick_count + 16'd1;
              end
            end else begin
              unique case (phase)
                PH_HUNT: begin
                  if (in_ch.rx_byte == start_byte) begin
                    phase      <= PH_LEN;
                    tick_count <= 16'd0;
                  end
                end
                PH_LEN: begin
                  frame_length <= in_ch.rx_byte;
                  byte_count   <= '0;
                  phase        <= PH_BODY;
                  state        <= S_CRC;
                end
                PH_BODY: begin
                  if (byte_count == '0) begin
                    cmd <= in_ch.rx_byte;
                  end
                  byte_count <= cnt_inc;
                  if (MW'(cnt_inc) >= MW'(frame_length)) begin
                    phase <= PH_CRC;
                  end
                  state <= S_CRC;
                end
                PH_CRC: begin
                  if (good) begin
                    pl_q    <= pl[5:0];
                    rd_addr <= AW'(1);
                    state   <= S_RD;
                    phase   <= PH_HUNT;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_CRC: begin
          if (!crc_stat.busy) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data   <= rd_data;
            out_has    <= 1'b1;
            out_last   <= rd_last;
            out_status <= STAT_OK;
            out_plen   <= pl_q;
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              rd_addr <= rd_addr + 1'b1;
              state   <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  crcfr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .req  (crc_req),
    .stat (crc_stat)
  );

  crcfr_body_buf #(
    .DEPTH (BODY_BYTES)
  ) u_body (
    .clk   (clk),
    .we    (mem_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (in_ch.rx_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.data_byte      = out_data;
  assign out_ch.has_data       = out_has;
  assign out_ch.last           = out_last;
  assign out_ch.status         = out_status;
  assign out_ch.payload_length = out_plen;

endmodule

/* rtl/core/crcfr_crc_unit.sv */
// crcfr_crc_unit: bit-serial CRC-8 (poly 0x07, MSB first), eight shifts a byte.
// Depends on crcfr_pkg.
module crcfr_crc_unit (
  input  logic                clk,
  input  logic                rst,
  input  crcfr_pkg::crc_req_t req,
  output crcfr_pkg::crc_stat_t stat
);
  import crcfr_pkg::*;

  logic [7:0] crc;
  logic [2:0] cnt;
  logic       busy;
  logic [7:0] crc_shift;

  assign crc_shift = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      crc  <= 8'd0;
      cnt  <= 3'd0;
      busy <= 1'b0;
    end else if (req.start) begin
      crc  <= req.seed;
      cnt  <= 3'd0;
      busy <= 1'b1;
    end else if (busy) begin
      crc <= crc_shift;
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.crc  = crc;

endmodule

/* rtl/core/crcfr_body_buf.sv */
// crcfr_body_buf: frame body store, one write port, registered read port.
// No dependencies.
module crcfr_body_buf #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/crc8_frame_receiver_unit_checker.sv */
// Checker for the CRC-8 frame receiver: follows register writes and accepted words,
// predicts result words and compares them on the output channel.
// Depends on crcfr_pkg and crcfr_if.
`timescale 1ns / 1ps

module crc8_frame_receiver_unit_checker
  import crcfr_pkg::*;
#(
  parameter int BODY_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  crcfr_in_if         in_ch,
  crcfr_out_if        out_ch,
  output int          fail_count,
  output int          words_pending
);

  localparam int REPORT_CAP = 50;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
    logic [2:0] status;
    logic [5:0] payload_length;
  } result_t;

  result_t expected_words[$];

  logic [7:0]  start_r;
  logic [7:0]  cmd_r;
  logic [5:0]  limit_r;
  logic [15:0] timeout_r;

  phase_t      rx_phase;
  logic [6:0]  frame_len;
  logic [6:0]  byte_cnt;
  logic [7:0]  crc_acc;
  logic [7:0]  body [BODY_BYTES];
  logic [15:0] ticks;

  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    int i;
    r = c ^ b;
    for (i = 0; i < 8; i++)
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function void push_result(input logic [7:0] d, input logic h, input logic l,
                            input logic [2:0] st, input logic [5:0] plen);
    result_t r;
    r.data_byte      = d;
    r.has_data       = h;
    r.last           = l;
    r.status         = st;
    r.payload_length = plen;
    expected_words.push_back(r);
  endfunction

  function void fail_frame(input logic [2:0] st);
    push_result(8'h00, 1'b0, 1'b1, st, 6'd0);
    rx_phase = PH_HUNT;
  endfunction

  function void predict_word(input logic k, input logic [7:0] b);
    logic [6:0] plen;
    int i;
    if (k) begin
      if (rx_phase != PH_HUNT) begin
        if (ticks >= timeout_r) fail_frame(STAT_TIMEOUT);
        else ticks = ticks + 16'd1;
      end
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (b == start_r) begin
            rx_phase  = PH_LEN;
            ticks     = 16'd0;
            byte_cnt  = 7'd0;
            frame_len = 7'd0;
            crc_acc   = 8'h00;
          end
        end
        PH_LEN: begin
          if (b == 8'd0) fail_frame(STAT_ZERO_LEN);
          else if (b > BODY_BYTES) fail_frame(STAT_TOO_LONG);
          else begin
            frame_len = b[6:0];
            byte_cnt  = 7'd0;
            crc_acc   = crc8_next(8'h00, b);
            rx_phase  = PH_BODY;
          end
        end
        PH_BODY: begin
          if (byte_cnt < BODY_BYTES) body[byte_cnt] = b;
          crc_acc  = crc8_next(crc_acc, b);
          byte_cnt = byte_cnt + 7'd1;
          if (byte_cnt >= frame_len) rx_phase = PH_CRC;
        end
        default: begin
          plen = frame_len - 7'd1;
          if (b != crc_acc) fail_frame(STAT_CRC_BAD);
          else if (body[0] != cmd_r) fail_frame(STAT_CMD_BAD);
          else if (plen > {1'b0, limit_r}) fail_frame(STAT_OVER_LIM);
          else begin
            rx_phase = PH_HUNT;
            if (plen == 7'd0) push_result(8'h00, 1'b0, 1'b1, STAT_OK, 6'd0);
            else
              for (i = 0; i < plen; i++)
                push_result(body[i + 1], 1'b1, (i + 1 == plen), STAT_OK, plen[5:0]);
          end
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      start_r    = START_BYTE_RST;
      cmd_r      = EXP_CMD_RST;
      limit_r    = PAYLOAD_LIM_RST;
      timeout_r  = TIMEOUT_RST;
      rx_phase   = PH_HUNT;
      frame_len  = 7'd0;
      byte_cnt   = 7'd0;
      crc_acc    = 8'h00;
      ticks      = 16'd0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_BYTE:  start_r   = cfg_data[7:0];
          REG_EXP_CMD:     cmd_r     = cfg_data[7:0];
          REG_PAYLOAD_LIM: limit_r   = cfg_data[5:0];
          REG_TIMEOUT:     timeout_r = cfg_data;
          default: ;
        endcase
      end
      // outgoing word first: it can only stem from words taken earlier
      if (out_ch.valid && out_ch.ready) begin
        got.data_byte      = out_ch.data_byte;
        got.has_data       = out_ch.has_data;
        got.last           = out_ch.last;
        got.status         = out_ch.status;
        got.payload_length = out_ch.payload_length;
        if (expected_words.size() == 0) begin
          if (fail_count < REPORT_CAP)
            $display("%0t: unexpected result word: data %02h has %0b last %0b st %0d len %0d",
                     $time, got.data_byte, got.has_data, got.last, got.status,
                     got.payload_length);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.data_byte !== want.data_byte || got.has_data !== want.has_data ||
              got.last !== want.last || got.status !== want.status ||
              got.payload_length !== want.payload_length) begin
            if (fail_count < REPORT_CAP)
              $display({"%0t: mismatch: expected data %02h has %0b last %0b st %0d len %0d,",
                        " actual data %02h has %0b last %0b st %0d len %0d"}, $time,
                       want.data_byte, want.has_data, want.last, want.status,
                       want.payload_length, got.data_byte, got.has_data, got.last,
                       got.status, got.payload_length);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.kind, in_ch.rx_byte);
    end
    words_pending = expected_words.size();
  end

endmodule

/* tb/crc8_frame_receiver_unit_test.sv */
// Top of the CRC-8 frame receiver testbench: clock, reset, register writes, word
// stimulus and result back-pressure; verdict from the checker's failure count.
// Depends on crcfr_pkg, crcfr_if, crc8_frame_receiver_unit and its checker.
`timescale 1ns / 1ps

module crc8_frame_receiver_unit_test;
  import crcfr_pkg::*;

  localparam int IDLE_PCT      = 9;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int END_CYCLES    = 40;
  localparam int RUN_LIMIT     = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          words_pending;

  bit          idle_on;
  int          hold_requests;
  int          items_sent;
  logic [7:0]  sb_cur;
  logic [7:0]  cmd_cur;

  crcfr_in_if  in_ch ();
  crcfr_out_if out_ch ();

  crc8_frame_receiver_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  crc8_frame_receiver_unit_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [7:0] frame_crc(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    int i;
    r = c ^ b;
    for (i = 0; i < 8; i++)
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  // entered and left just after a falling edge; valid is left up on return
  task automatic send_word(input logic k, input logic [7:0] b);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic maybe_ticks(input int pct);
    int n;
    n = 0;
    while (n < 4 && $urandom_range(0, 99) < pct) begin
      send_word(1'b1, 8'($urandom_range(0, 255)));
      n++;
    end
  endtask

  // 0 <= cut < len stops the body early (no CRC); fill >= 0 fixes the payload bytes
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input logic [7:0] flip, input int cut, input int pct,
                            input int fill);
    logic [7:0] crc;
    logic [7:0] b;
    int n_body;
    int i;
    send_word(1'b0, sb_cur);
    maybe_ticks(pct);
    send_word(1'b0, len);
    if (len != 8'd0 && len <= 8'd64) begin
      crc    = frame_crc(8'h00, len);
      n_body = (cut >= 0 && cut < int'(len)) ? cut : int'(len);
      for (i = 0; i < n_body; i++) begin
        if (i == 0) b = cmd;
        else if (fill >= 0) b = fill[7:0];
        else b = 8'($urandom_range(0, 255));
        maybe_ticks(pct);
        send_word(1'b0, b);
        crc = frame_crc(crc, b);
      end
      if (n_body == int'(len)) begin
        maybe_ticks(pct);
        send_word(1'b0, crc ^ flip);
      end
    end
  endtask

  task automatic random_traffic(input int n, input int pct);
    int stop;
    int r;
    int len;
    logic [7:0] cmd;
    logic [7:0] flip;
    stop = items_sent + n;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r    = $urandom_range(0, 99);
        len  = (r < 85) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 20)
                                                           : $urandom_range(21, 64);
        cmd  = ($urandom_range(0, 99) < 90) ? cmd_cur : 8'($urandom_range(0, 255));
        flip = ($urandom_range(0, 99) < 88) ? 8'h00 : 8'($urandom_range(1, 255));
        send_frame(8'(len), cmd, flip, -1, pct, -1);
      end else if (r < 82) begin
        send_word($urandom_range(0, 99) < 30, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        len = $urandom_range(0, 1) ? 0 : $urandom_range(65, 255);
        send_frame(8'(len), cmd_cur, 8'h00, -1, pct, -1);
      end else begin
        len = $urandom_range(2, 8);
        send_frame(8'(len), cmd_cur, 8'h00, $urandom_range(0, len - 1), pct, -1);
      end
    end
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [7:0] cmd,
                            input logic [5:0] lim, input logic [15:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_data  <= {8'h00, sb};
    @(negedge clk);
    cfg_index <= REG_EXP_CMD;
    cfg_data  <= {8'h00, cmd};
    @(negedge clk);
    cfg_index <= REG_PAYLOAD_LIM;
    cfg_data  <= {10'd0, lim};
    @(negedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= tmo;
    @(negedge clk);
    cfg_we  <= 1'b0;
    sb_cur  = sb;
    cmd_cur = cmd;
  endtask

  // a body word can still be in the CRC shifter once the last result is out
  task automatic drain_results;
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_START_BYTE;
    cfg_data      <= 16'd0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    idle_on       = 1'b1;
    hold_requests = 0;
    items_sent    = 0;
    sb_cur        = START_BYTE_RST;
    cmd_cur       = EXP_CMD_RST;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed, register defaults
    send_word(1'b1, 8'h5A);                         // tick while hunting
    send_word(1'b0, 8'h00);                         // noise while hunting
    send_frame(8'd1, 8'h00, 8'h00, -1, 0, -1);      // good, empty payload
    send_frame(8'd0, 8'h00, 8'h00, -1, 0, -1);      // zero length
    send_frame(8'd65, 8'h00, 8'h00, -1, 0, -1);     // just too long
    send_frame(8'd255, 8'h00, 8'h00, -1, 0, -1);
    send_frame(8'd2, 8'h00, 8'h00, -1, 0, 170);     // start value inside the frame
    send_frame(8'd1, 8'h00, 8'h01, -1, 0, -1);      // bad CRC
    send_frame(8'd1, 8'h55, 8'h00, -1, 0, -1);      // wrong command
    drain_results();

    set_config(8'd170, 8'd0, 6'd0, 16'd1);
    send_frame(8'd2, 8'h00, 8'h00, -1, 0, 255);     // payload over limit
    send_word(1'b0, sb_cur);
    send_word(1'b1, 8'hA5);
    send_word(1'b1, 8'h3C);                         // frame timeout
    drain_results();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               6'($urandom_range(0, 63)), 16'hFFFF);
    random_traffic(22, 5);
    drain_results();

    idle_on = 1'b0;
    set_config(8'd0, 8'd255, 6'd63, 16'hFFFF);
    random_traffic(18, 3);
    drain_results();

    idle_on = 1'b1;
    set_config(8'd255, 8'($urandom_range(0, 255)), 6'd63, 16'hFFFF);
    hold_requests++;
    repeat (3) send_frame(8'($urandom_range(3, 8)), cmd_cur, 8'h00, -1, 0, -1);
    random_traffic(8, 0);
    drain_results();

    set_config(8'($urandom_range(0, 255)), 8'd0, 6'($urandom_range(0, 63)),
               16'($urandom_range(1, 6)));
    random_traffic(22, 25);
    drain_results();
    repeat (END_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
